### src/mavg_pkg.sv
// Package for the moving average filter: field widths, default sizes and
// the command and status structs between the controller and the datapath.
// Used by every module of the block; depends on nothing else.
package mavg_pkg;

    // Fixed field widths of the stream and configuration words.
    localparam int DATA_W         = 32;
    localparam int WLEN_W         = 7;
    localparam int MEAN_W         = 48;
    localparam int FRAC_W         = 16;

    // Default delay line depth.
    localparam int WINDOW_MAX_DEF = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // take the input word into the sample register
        logic read;       // read the delay line slot being replaced
        logic update;     // write the slot, update the sum and counters
        logic load_out;   // move the finished mean into the output register
        logic cfg_write;  // take a new window length and clear the window
    } mavg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_result; // the sample being updated completes a full window
        logic div_busy;   // the divider is still iterating
        logic out_free;   // the output register can take a new word
    } mavg_status_t;

endpackage

### src/mavg_div.sv
// Bit-serial restoring divider for the window mean: (|sum| << 16) / window.
// One quotient bit per cycle. Depends on mavg_pkg.
module mavg_div #(
    parameter int SUM_W = 38,
    parameter int CNT_W = 7
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [SUM_W-1:0]                sum,
    input  logic        [CNT_W-1:0]                divisor,
    output logic                                   busy,
    output logic                                   neg,
    output logic        [mavg_pkg::MEAN_W-1:0]     quotient
);
    import mavg_pkg::*;

    localparam int DIV_W  = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  work_reg;
    logic [DIV_W-1:0]  work_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  divisor_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              neg_reg;
    logic [SUM_W-1:0]  mag;
    logic [CNT_W:0]    rem_shift;
    logic              fits;

    // Magnitude of the signed sum.
    assign mag = sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum)) : SUM_W'(sum);

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, work_reg[DIV_W-1]};
        fits      = (rem_shift >= {1'b0, divisor_reg});
        rem_next  = fits ? CNT_W'(rem_shift - {1'b0, divisor_reg}) : rem_shift[CNT_W-1:0];
        work_next = {work_reg[DIV_W-2:0], fits};
        step_next = step_reg - STEP_W'(1);
    end

    // Step counter; the divider is busy while it is nonzero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(DIV_W);
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_next;
        end
    end

    // Dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg    <= {mag, FRAC_W'(0)};
            rem_reg     <= '0;
            divisor_reg <= divisor;
            neg_reg     <= sum[SUM_W-1];
        end
        else if (step_reg != '0)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy     = (step_reg != '0);
    assign neg      = neg_reg;
    assign quotient = work_reg[MEAN_W-1:0];

endmodule

### src/mavg_dp.sv
// Datapath of the moving average filter: window length register, delay line
// memory, running sum and counters, the divider and the output register.
// Depends on mavg_pkg and mavg_div.
module mavg_dp #(
    parameter int WINDOW_MAX = mavg_pkg::WINDOW_MAX_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mavg_pkg::mavg_cmd_t                  cmd,
    output mavg_pkg::mavg_status_t               status,
    input  logic signed [mavg_pkg::DATA_W-1:0]   in_sample,
    input  logic                                 in_last,
    input  logic        [mavg_pkg::WLEN_W-1:0]   cfg_data,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic        [mavg_pkg::MEAN_W-1:0]   m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import mavg_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = DATA_W + $clog2(WINDOW_MAX);

    logic        [WLEN_W-1:0] window_len_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] old_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic        [CNT_W-1:0]  fill_reg;
    logic        [CNT_W-1:0]  fill_next;
    logic        [CNT_W-1:0]  fill_inc;
    logic        [SLOT_W-1:0] slot_reg;
    logic        [SLOT_W-1:0] slot_next;
    logic        [CNT_W-1:0]  slot_inc;
    logic        [CNT_W-1:0]  eff_w;
    logic                     full;
    logic                     has_result;
    logic                     out_valid_reg;
    logic        [MEAN_W-1:0] out_mean_reg;
    logic                     out_last_reg;
    logic        [MEAN_W-1:0] mean;
    logic                     div_busy;
    logic                     div_neg;
    logic        [MEAN_W-1:0] div_q;
    logic                     out_free;

    logic signed [DATA_W-1:0] mem [WINDOW_MAX];

    // Effective window: zero counts as one, anything above the depth as the depth.
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            eff_w = CNT_W'(1);
        end
        else if (int'(window_len_reg) > WINDOW_MAX)
        begin
            eff_w = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_w = CNT_W'(window_len_reg);
        end
    end

    // Next sum, fill count and ring position for the sample being taken in.
    always_comb
    begin
        full       = (fill_reg >= eff_w);
        fill_inc   = fill_reg + CNT_W'(1);
        fill_next  = full ? fill_reg : fill_inc;
        has_result = full || (fill_inc == eff_w);
        sum_next   = sum_reg + SUM_W'(sample_reg) - (full ? SUM_W'(old_reg) : SUM_W'(0));
        slot_inc   = CNT_W'(slot_reg) + CNT_W'(1);
        slot_next  = (slot_inc >= eff_w) ? '0 : SLOT_W'(slot_inc);
    end

    // Captured input word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_sample;
            last_reg   <= in_last;
        end
    end

    // Delay line memory: registered read of the slot, write on update.
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            old_reg <= mem[slot_reg];
        end
        if (cmd.update)
        begin
            mem[slot_reg] <= sample_reg;
        end
    end

    // Window state. A series end or a new window length clears it; the memory
    // needs no clearing since an old slot value is only used once the window
    // is full, and by then this series has written every slot in it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WLEN_W'(1);
            sum_reg        <= '0;
            fill_reg       <= '0;
            slot_reg       <= '0;
        end
        else if (cmd.cfg_write)
        begin
            window_len_reg <= cfg_data;
            sum_reg        <= '0;
            fill_reg       <= '0;
            slot_reg       <= '0;
        end
        else if (cmd.update)
        begin
            if (last_reg)
            begin
                sum_reg  <= '0;
                fill_reg <= '0;
                slot_reg <= '0;
            end
            else
            begin
                sum_reg  <= sum_next;
                fill_reg <= fill_next;
                slot_reg <= slot_next;
            end
        end
    end

    // Divider takes its own copy of the sum, so the window may clear meanwhile.
    mavg_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.update && has_result),
        .sum      (sum_next),
        .divisor  (eff_w),
        .busy     (div_busy),
        .neg      (div_neg),
        .quotient (div_q)
    );

    // Apply the sign to the truncated magnitude quotient.
    assign mean = div_neg ? (MEAN_W'(0) - div_q) : div_q;

    // Output register: holds a word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_mean_reg <= mean;
            out_last_reg <= last_reg;
        end
    end

    assign out_free          = !out_valid_reg || m_axis_tready;
    assign status.has_result = has_result;
    assign status.div_busy   = div_busy;
    assign status.out_free   = out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_mean_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // The fill count never passes the window it counts toward.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_w)
        else $error("fill count above window length");

    // The ring position stays inside the window.
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(slot_reg) < eff_w)
        else $error("write slot outside window");

    // A mean is only loaded once the divider finished and the output is free.
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!div_busy && out_free))
        else $error("output loaded while divider busy or output full");

    // Starting a division makes the divider busy from the next cycle on.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && has_result) |=> div_busy)
        else $error("divider did not start");
`endif

endmodule

### src/mavg_ctrl.sv
// Controller of the moving average filter: sequences read, update, divide
// and delivery for one input word at a time. Depends on mavg_pkg.
module mavg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  mavg_pkg::mavg_status_t  status,
    output mavg_pkg::mavg_cmd_t     cmd
);
    import mavg_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_READ    = 3'd1;
    localparam logic [2:0] ST_UPDATE  = 3'd2;
    localparam logic [2:0] ST_DIVIDE  = 3'd3;
    localparam logic [2:0] ST_DELIVER = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        cfg_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cfg_ready     = 1'b1;
                s_axis_tready = !cfg_valid;
                cmd.cfg_write = cfg_valid;
                cmd.capture   = s_axis_tvalid && !cfg_valid;
                if (s_axis_tvalid && !cfg_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.has_result ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/moving_average_filter_core.sv
// Moving average filter. A word is accepted in idle, its delay line slot read
// and then updated; a full window then runs a bit-serial divider of
// 32 + log2(WINDOW_MAX) + 16 steps (54 at the default depth) before the
// mean is loaded, and only then is the next word accepted.
// The next word is accepted while the previous mean waits in the output register.
// Reset (async, active low) sets the window length to 1 and empties the window.
module moving_average_filter_core #(
    parameter int WINDOW_MAX = mavg_pkg::WINDOW_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mavg_pkg::DATA_W-1:0]         s_axis_tdata,  // [31:0] sample
    input  logic                                s_axis_tlast,  // series_end
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mavg_pkg::MEAN_W-1:0]         m_axis_tdata,  // [47:0] mean_q16
    output logic                                m_axis_tlast,  // last_of_series
    // Window length register.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mavg_pkg::WLEN_W-1:0]         cfg_data       // window_len
);
    import mavg_pkg::*;

    mavg_cmd_t    cmd;
    mavg_status_t status;

    // Sequencer.
    mavg_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .status        (status),
        .cmd           (cmd)
    );

    // Window state, divider and output register.
    mavg_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_sample     (DATA_W'(s_axis_tdata)),
        .in_last       (s_axis_tlast),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for moving_average_filter_core: drives sample words with
// random gaps, predicts every window mean, and compares each result word in order.
// Depends on mavg_pkg and moving_average_filter_core only.
module tb;
    import mavg_pkg::*;

    localparam int DEPTH      = WINDOW_MAX_DEF;
    localparam int SETTLE_CYC = 80;       // covers one full mean computation
    localparam int HOLD_CYC   = 400;      // long result back-pressure stretch
    localparam int PHASE_WORDS = 85;

    typedef struct {
        logic [MEAN_W-1:0] mean;
        logic              last;
    } mean_word_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata;    // [31:0] sample
    logic                s_axis_tlast;    // series_end
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [MEAN_W-1:0]   m_axis_tdata;    // [47:0] mean_q16
    logic                m_axis_tlast;    // last_of_series
    logic                cfg_valid;
    logic                cfg_ready;
    logic [WLEN_W-1:0]   cfg_data;        // window_len

    // Filter state mirrored by the predictor.
    logic [WLEN_W-1:0]   win_len_reg;
    longint              window_mem [DEPTH];
    longint              window_sum;
    int unsigned         fill_count;
    int unsigned         write_slot;
    mean_word_t          mean_queue[$];

    int                  errors = 0;
    bit                  tx_idle_on = 1'b0;
    bit                  rx_idle_on = 1'b0;
    bit                  hold_pending = 1'b0;

    moving_average_filter_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic int effective_len();
        if (win_len_reg == 0)
            return 1;
        if (win_len_reg > DEPTH)
            return DEPTH;
        return win_len_reg;
    endfunction

    function automatic logic [DATA_W-1:0] extreme_sample();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return extreme_sample();
            1, 2, 3: return DATA_W'($urandom_range(0, 2000)) - DATA_W'(1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_filter();
        foreach (window_mem[i])
            window_mem[i] = 0;
        window_sum = 0;
        fill_count = 0;
        write_slot = 0;
    endtask

    // Advances the predicted filter by one accepted sample and queues its mean.
    task automatic advance_filter(input logic [DATA_W-1:0] smp, input logic end_flag);
        int unsigned       w;
        longint            s;
        longint unsigned   mag;
        longint unsigned   q;
        mean_word_t        m;
        w = effective_len();
        s = longint'($signed(smp));
        if (write_slot >= w)
            write_slot = 0;
        if (fill_count >= w)
            window_sum -= window_mem[write_slot];
        else
            fill_count++;
        window_mem[write_slot] = s;
        window_sum += s;
        write_slot++;
        if (write_slot >= w)
            write_slot = 0;
        if (fill_count >= w)
        begin
            mag = (window_sum < 0) ? -window_sum : window_sum;
            q = (mag << FRAC_W) / w;
            if (window_sum < 0)
                q = -q;
            m.mean = q[MEAN_W-1:0];
            m.last = end_flag;
            mean_queue.insert(mean_queue.size(), m);
        end
        if (end_flag)
            clear_filter();
    endtask

    // Offers one sample word, keeping tvalid high between back-to-back words.
    task automatic send_word(input logic [DATA_W-1:0] smp, input logic end_flag);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= end_flag;
        do @(posedge clk); while (!s_axis_tready);
        advance_filter(smp, end_flag);
    endtask

    // Stops the input stream and waits until the block has drained.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (mean_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_window_len(input logic [WLEN_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len_reg = value;
        clear_filter();
    endtask

    // Sends series of random length; a few end before the window fills.
    task automatic run_series(input int budget);
        int   sent;
        int   len;
        int   w;
        bit   flat_run;
        logic [DATA_W-1:0] flat_val;
        sent = 0;
        w = effective_len();
        while (sent < budget)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(1, w);
            else
                len = w + $urandom_range(0, 2 * w + 8);
            flat_run = ($urandom_range(0, 15) == 0);
            flat_val = extreme_sample();
            for (int i = 0; i < len && sent < budget; i++)
            begin
                send_word(flat_run ? flat_val : random_sample(), i == len - 1);
                sent++;
            end
        end
    endtask

    // Reset window of one: every sample is its own mean, field extremes included.
    task automatic test_reset_window();
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
    endtask

    // Zero length acts as one; short series; truncation toward zero; clamped length.
    task automatic test_directed_windows();
        write_window_len(7'd0);
        send_word(32'd5, 1'b0);
        send_word(-32'sd7, 1'b1);
        write_window_len(7'd2);
        send_word(32'd9, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        write_window_len(7'd3);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        write_window_len(7'd127);
        send_word(32'd1, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'd3, 1'b1);
    endtask

    // Random traffic over the length extremes and a spread of other lengths.
    task automatic test_random_windows();
        logic [WLEN_W-1:0] lens [8];
        lens = '{7'd64, 7'd127, 7'd65, 7'd1, 7'd2, 7'd0, 7'd63, 7'd4};
        for (int p = 0; p < 14; p++)
        begin
            if (p < 8)
                write_window_len(lens[p]);
            else
                write_window_len(WLEN_W'($urandom_range(1, 40)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            run_series(PHASE_WORDS);
        end
    endtask

    // Results are held off for a long stretch while samples keep coming.
    task automatic test_backpressure();
        write_window_len(7'd1);
        tx_idle_on = 1'b0;
        hold_pending = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(random_sample(), $urandom_range(0, 3) == 0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Result side ready generation, including the long hold-off.
    initial
    begin : result_sink
        m_axis_tready = 1'b0;
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result word against the oldest predicted mean.
    always @(posedge clk)
    begin : check_results
        mean_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (mean_queue.size() == 0)
                report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
            else
            begin
                want = mean_queue.pop_front();
                if (m_axis_tdata !== want.mean)
                    report_mismatch($sformatf("mean_q16 %h, expected %h",
                                              m_axis_tdata, want.mean));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last_of_series %b, expected %b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    initial
    begin : watchdog
        #12_000_000;
        $display("moving_average_filter_core test failed");
        $finish;
    end

    initial
    begin : main_sequence
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        win_len_reg   = 7'd1;
        clear_filter();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_directed_windows();
        test_random_windows();
        test_backpressure();

        wait_idle();
        if (mean_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", mean_queue.size()));
        if (errors == 0)
            $display("moving_average_filter_core test passed");
        else
            $display("moving_average_filter_core test failed");
        $finish;
    end

endmodule

### moving_average_filter_core.f
src/mavg_pkg.sv
src/mavg_div.sv
src/mavg_dp.sv
src/mavg_ctrl.sv
src/moving_average_filter_core.sv
tb/tb.sv
